>>> src/binary_element_format_converter_core_defines.svh
// Assertion macros for the converter's RTL; befc_queue is the file that uses them.
// Define ASSERT_OFF to compile every assertion away.
`ifndef BINARY_ELEMENT_FORMAT_CONVERTER_CORE_DEFINES_SVH
`define BINARY_ELEMENT_FORMAT_CONVERTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every rising clk_i edge outside reset.
`define BEFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never be seen outside reset.
`define BEFC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BEFC_ASSERT(label, prop, msg)
`define BEFC_ASSERT_NEVER(label, cond, msg)
`endif

`endif

>>> src/befc_pkg.sv
// Shared types, constants and helper functions of the element converter.
// No dependencies; every module of the block imports this package.
package befc_pkg;

  localparam int unsigned MaxSourceBytesDefault = 16;
  localparam int unsigned QueueDepthDefault     = 2;
  localparam int unsigned SwapMaxBytes          = 8;
  // Holds any element size, which the 5-bit source size field limits to 31 bytes.
  localparam int unsigned SizeW                 = 6;
  localparam int unsigned CfgIdxW               = 3;
  localparam int unsigned CfgDataW              = 5;

  typedef enum logic [1:0] {
    MODE_PASS   = 2'd0,
    MODE_SWAP   = 2'd1,
    MODE_RESIZE = 2'd2,
    MODE_BOOL   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE          = 3'd0,
    CFG_LITTLE_ENDIAN = 3'd1,
    CFG_SOURCE_BYTES  = 3'd2,
    CFG_DEST_SIZE     = 3'd3,
    CFG_DEST_UNSIGNED = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    mode_e       mode;
    logic        little;
    logic [4:0]  src_bytes;
    logic [1:0]  dsize;
    logic        uns;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    mode:      MODE_PASS,
    little:    1'b1,
    src_bytes: 5'd4,
    dsize:     2'd2,
    uns:       1'b0
  };

  // One assembled element handed from the front to the back.
  typedef struct packed {
    logic [63:0]      assembled;
    logic [SizeW-1:0] nbytes;
    logic             sign;
    logic             nonzero;
    logic             last;
  } elem_t;

  // Mask covering the low 'bytes' bytes of a 64-bit word.
  function automatic logic [63:0] low_mask(input logic [SizeW-1:0] bytes);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (bytes > SizeW'(i)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

>>> src/befc_front.sv
// Front end: takes source bytes, tracks the element size and assembles each
// element, then pushes it to the queue. Depends on befc_pkg.
module befc_front #(
  parameter int unsigned MAX_SOURCE_BYTES = befc_pkg::MaxSourceBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  befc_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  input  logic           in_end_i,
  input  logic           q_full_i,
  output logic           push_o,
  output befc_pkg::elem_t push_elem_o
);
  import befc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SOURCE_BYTES + 1);

  logic [CntW-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [63:0]      asm_q, asm_d, asm_nx;
  logic             sign_q, sign_d, sign_nx;
  logic             nz_q, nz_d, nz_nx;
  logic [SizeW-1:0] sb_ext, nbytes;
  logic             little, accept, complete;

  // Effective element size: zero reads as one, large sizes saturate, and
  // pass or swap modes stop at eight bytes.
  always_comb begin
    sb_ext = SizeW'(cfg_i.src_bytes);
    nbytes = sb_ext;
    if (sb_ext == '0) nbytes = SizeW'(1);
    if (nbytes > SizeW'(MAX_SOURCE_BYTES)) nbytes = SizeW'(MAX_SOURCE_BYTES);
    if ((cfg_i.mode == MODE_PASS || cfg_i.mode == MODE_SWAP) &&
        nbytes > SizeW'(SwapMaxBytes)) begin
      nbytes = SizeW'(SwapMaxBytes);
    end
  end

  // A byte order change in the middle of an element leaves shifted bytes in
  // the word, so the little-endian path merges into what is already there.
  always_comb begin
    little = (cfg_i.mode == MODE_PASS) ? 1'b1 :
             (cfg_i.mode == MODE_SWAP) ? 1'b0 : cfg_i.little;
    asm_nx  = asm_q;
    sign_nx = sign_q;
    if (little) begin
      for (int i = 0; i < 8; i++) begin
        if (cnt_q == CntW'(i)) asm_nx[8*i +: 8] = asm_q[8*i +: 8] | in_byte_i;
      end
      sign_nx = in_byte_i[7];
    end else begin
      asm_nx = {asm_q[55:0], in_byte_i};
      if (cnt_q == '0) sign_nx = in_byte_i[7];
    end
    nz_nx    = nz_q | (in_byte_i != 8'h00);
    cnt_inc  = cnt_q + CntW'(1);
    complete = (SizeW'(cnt_inc) >= nbytes);
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && complete;

  assign push_elem_o = '{
    assembled: asm_nx,
    nbytes:    nbytes,
    sign:      sign_nx,
    nonzero:   nz_nx,
    last:      in_end_i
  };

  always_comb begin
    cnt_d  = cnt_q;
    asm_d  = asm_q;
    sign_d = sign_q;
    nz_d   = nz_q;
    if (accept) begin
      if (complete || in_end_i) begin
        cnt_d  = '0;
        asm_d  = '0;
        sign_d = 1'b0;
        nz_d   = 1'b0;
      end else begin
        cnt_d  = cnt_inc;
        asm_d  = asm_nx;
        sign_d = sign_nx;
        nz_d   = nz_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      asm_q  <= '0;
      sign_q <= 1'b0;
      nz_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      asm_q  <= asm_d;
      sign_q <= sign_d;
      nz_q   <= nz_d;
    end
  end

endmodule

>>> src/befc_queue.sv
// Short register queue of assembled elements between front and back.
// Depends on befc_pkg and the assertion macros of the defines header.
`include "binary_element_format_converter_core_defines.svh"
module befc_queue #(
  parameter int unsigned DEPTH = befc_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  befc_pkg::elem_t push_elem_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output befc_pkg::elem_t head_o
);
  import befc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  elem_t           mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    if (do_pop)  rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_elem_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  `BEFC_ASSERT_NEVER(a_cnt_bound, cnt_q > CntW'(DEPTH), "queue count beyond depth")
  `BEFC_ASSERT_NEVER(a_push_full, push_i && full_o, "element pushed into a full queue")
  `BEFC_ASSERT(a_cnt_grow, (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)), "queue count did not grow on push")

endmodule

>>> src/befc_back.sv
// Back end: turns a queued element into its result and holds it in the
// output register until taken. Depends on befc_pkg.
module befc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  befc_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  befc_pkg::elem_t q_head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [63:0]     out_value_o,
  output logic            out_last_o
);
  import befc_pkg::*;

  logic             valid_q, valid_d;
  logic [63:0]      value_q, value_d, src_mask;
  logic             last_q;
  logic [SizeW-1:0] dbytes;

  assign pop_o   = q_valid_i && (!valid_q || out_ready_i);
  assign valid_d = pop_o || (valid_q && !out_ready_i);

  always_comb begin
    src_mask = low_mask(q_head_i.nbytes);
    dbytes   = SizeW'(1) << cfg_i.dsize;
    unique case (cfg_i.mode)
      MODE_PASS, MODE_SWAP: value_d = q_head_i.assembled & src_mask;
      MODE_RESIZE: begin
        value_d = q_head_i.assembled;
        // Sign extension only where the source is narrower than the result.
        if (!cfg_i.uns && (q_head_i.nbytes < dbytes) && q_head_i.sign) begin
          value_d = value_d | ~src_mask;
        end
        value_d = value_d & low_mask(dbytes);
      end
      MODE_BOOL: value_d = {63'd0, q_head_i.nonzero};
      default:   value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      value_q <= value_d;
      last_q  <= q_head_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_value_o = value_q;
  assign out_last_o  = last_q;

endmodule

>>> src/binary_element_format_converter_core.sv
// Top level of the binary element format converter: configuration registers,
// front end, element queue and back end. Depends on befc_pkg and all befc_* modules.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tdata[7:0] source byte, tlast marks the array's last byte
//   m_axis    out        tdata[63:0] converted element, tlast marks the array's end
//   cfg       in         write enable, register index, write data; no read-back
//
// The block takes one source byte in every cycle while the element queue has
// room, so the sustained rate is one byte per cycle, set by the single byte
// assembly register in the front end. A result appears on m_axis once the
// beat that completes its element has entered the queue and the back end has
// registered it. A stalled m_axis fills the queue and then drops s_axis_tready;
// the input side resumes as soon as the queue count shows room.
// Reset clears the element state, the queue pointers and the output valid, and
// loads the configuration defaults; there is no clearing pass.
module binary_element_format_converter_core #(
  parameter int unsigned MAX_SOURCE_BYTES = befc_pkg::MaxSourceBytesDefault,
  parameter int unsigned QUEUE_DEPTH      = befc_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [befc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [befc_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Source byte stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // array_end
  // Converted element stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,  // [63:0] value
  output logic                          m_axis_tlast   // last
);
  import befc_pkg::*;

  cfg_t  cfg_q, cfg_d;
  elem_t push_elem, head_elem;
  logic  push, q_full, q_valid, pop;

  // Configuration writes land at once; writes to unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:          cfg_d.mode      = mode_e'(cfg_wdata_i[1:0]);
        CFG_LITTLE_ENDIAN: cfg_d.little    = cfg_wdata_i[0];
        CFG_SOURCE_BYTES:  cfg_d.src_bytes = cfg_wdata_i[4:0];
        CFG_DEST_SIZE:     cfg_d.dsize     = cfg_wdata_i[1:0];
        CFG_DEST_UNSIGNED: cfg_d.uns       = cfg_wdata_i[0];
        default:           cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end assembles bytes into elements.
  befc_front #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_end_i   (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_elem_o(push_elem)
  );

  // The queue lets the front keep taking bytes while a result waits.
  befc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_elem_i(push_elem),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head_elem)
  );

  // The back end converts and registers each result.
  befc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_head_i   (head_elem),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_value_o(m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

>>> tb/sv/tb_binary_element_format_converter_core.sv
// Self-checking testbench for binary_element_format_converter_core.
// Needs befc_pkg and the converter RTL; a built-in predictor checks every
// converted element beat against the source bytes sent in.
`timescale 1ns / 1ps

module tb_binary_element_format_converter_core;
  import befc_pkg::*;

  localparam int unsigned ClkHalfPeriod = 10;
  localparam int unsigned CycleLimit    = 400000;
  // Idle wait after draining, with margin for the element queue and output register.
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned RandomPhases  = 16;
  localparam int unsigned PhaseBeats    = 40;
  localparam int unsigned MaxReports    = 10;
  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } src_beat_t;

  typedef struct packed {
    logic [63:0] value;
    logic        last;
  } elem_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [63:0]         m_axis_tdata;
  logic                m_axis_tlast;

  binary_element_format_converter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(ClkHalfPeriod) clk_i = ~clk_i;

  // Shadow copy of the configuration registers, loaded with reset values.
  mode_e      cfg_mode      = MODE_PASS;
  logic       cfg_little    = 1'b1;
  logic [4:0] cfg_src_bytes = 5'd4;
  logic [1:0] cfg_dsize     = 2'd2;
  logic       cfg_uns       = 1'b0;

  // Element assembly state of the predictor.
  logic [5:0]  asm_count    = '0;
  logic [63:0] asm_word     = '0;
  logic        asm_sign     = 1'b0;
  logic        asm_nonzero  = 1'b0;

  src_beat_t    pending_beats[$];
  elem_result_t expected_elems[$];
  src_beat_t    next_beat;
  elem_result_t oldest_elem;

  int unsigned pushed_beats   = 0;
  int unsigned accepted_beats = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Bytes that make up one element under the current settings.
  function automatic int unsigned current_elem_bytes();
    int unsigned n;
    n = cfg_src_bytes;
    if (n == 0) n = 1;
    if (n > MaxSourceBytesDefault) n = MaxSourceBytesDefault;
    if ((cfg_mode == MODE_PASS || cfg_mode == MODE_SWAP) && n > SwapMaxBytes) n = SwapMaxBytes;
    return n;
  endfunction

  function automatic logic [63:0] keep_mask(int unsigned nbytes);
    if (nbytes >= 8) return '1;
    return (64'd1 << (8 * nbytes)) - 64'd1;
  endfunction

  function automatic void clear_assembly();
    asm_count   = '0;
    asm_word    = '0;
    asm_sign    = 1'b0;
    asm_nonzero = 1'b0;
  endfunction

  // Folds one accepted source byte into the element and queues the
  // converted value once the element is complete.
  function automatic void convert_byte(logic [7:0] b, logic array_end);
    int unsigned  n;
    int unsigned  dbytes;
    logic         little;
    elem_result_t res;
    n = current_elem_bytes();
    case (cfg_mode)
      MODE_PASS: little = 1'b1;
      MODE_SWAP: little = 1'b0;
      default:   little = cfg_little;
    endcase
    if (little) begin
      if (asm_count < 8) asm_word |= 64'(b) << (8 * asm_count);
      asm_sign = b[7];
    end else begin
      asm_word = {asm_word[55:0], b};
      if (asm_count == 0) asm_sign = b[7];
    end
    if (b != 8'h00) asm_nonzero = 1'b1;
    if (asm_count < 6'd63) asm_count++;
    if (asm_count < n) begin
      // An array that ends inside an element drops the partial bytes.
      if (array_end) clear_assembly();
      return;
    end
    case (cfg_mode)
      MODE_PASS, MODE_SWAP: res.value = asm_word & keep_mask(n);
      MODE_RESIZE: begin
        dbytes = 1 << cfg_dsize;
        res.value = asm_word;
        if (!cfg_uns && n < dbytes && asm_sign) res.value |= ~keep_mask(n);
        res.value &= keep_mask(dbytes);
      end
      default: res.value = asm_nonzero ? 64'd1 : 64'd0;
    endcase
    res.last = array_end;
    expected_elems.push_back(res);
    clear_assembly();
  endfunction

  function automatic void push_beat(logic [7:0] b, logic l);
    pending_beats.push_back('{data: b, last: l});
    pushed_beats++;
  endfunction

  // Byte values weighted toward zero and the sign boundaries.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0, 1:    return 8'h00;
      2:       return 8'hFF;
      3:       return 8'h80;
      4:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_MODE:          cfg_mode      = mode_e'(data[1:0]);
      CFG_LITTLE_ENDIAN: cfg_little    = data[0];
      CFG_SOURCE_BYTES:  cfg_src_bytes = data[4:0];
      CFG_DEST_SIZE:     cfg_dsize     = data[1:0];
      CFG_DEST_UNSIGNED: cfg_uns       = data[0];
      default: ;
    endcase
  endtask

  // Waits until every pushed beat is taken and every element has come out,
  // then lets the pipeline settle in case the last byte made no element.
  task automatic wait_idle();
    while (accepted_beats != pushed_beats || expected_elems.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Source driver: holds a beat until it is taken, then maybe idles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        convert_byte(s_axis_tdata, s_axis_tlast);
        accepted_beats++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_beat.data;
          s_axis_tlast  <= next_beat.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_elems.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("unexpected element beat: value %h last %b", m_axis_tdata, m_axis_tlast);
        end else begin
          oldest_elem = expected_elems.pop_front();
          if (m_axis_tdata !== oldest_elem.value || m_axis_tlast !== oldest_elem.last) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("element mismatch: value exp %h got %h, last exp %b got %b",
                       oldest_elem.value, m_axis_tdata, oldest_elem.last, m_axis_tlast);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned kind;
    int unsigned elems;
    int unsigned total;
    int unsigned phase_beats;
    int unsigned src_sel;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling. Reset settings: pass through, four bytes.
    write_reg(CfgIdxSpare, 5'h1F);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'h80, 1'b0);
    push_beat(8'h01, 1'b1);
    wait_idle();

    // Byte reversal of two-byte elements, then an array ending mid-element.
    write_reg(CFG_MODE, {3'b111, MODE_SWAP});
    write_reg(CFG_SOURCE_BYTES, 5'd2);
    push_beat(8'h12, 1'b0);
    push_beat(8'h34, 1'b0);
    push_beat(8'hAA, 1'b1);
    wait_idle();

    // One-byte big-endian source sign-extended to eight bytes.
    write_reg(CFG_MODE, {3'b000, MODE_RESIZE});
    write_reg(CFG_LITTLE_ENDIAN, 5'd0);
    write_reg(CFG_SOURCE_BYTES, 5'd1);
    write_reg(CFG_DEST_SIZE, 5'd3);
    write_reg(CFG_DEST_UNSIGNED, 5'd0);
    push_beat(8'h80, 1'b0);
    push_beat(8'h7F, 1'b1);
    wait_idle();

    // Three-byte little-endian source truncated to one unsigned byte.
    write_reg(CFG_LITTLE_ENDIAN, 5'd1);
    write_reg(CFG_SOURCE_BYTES, 5'd3);
    write_reg(CFG_DEST_SIZE, 5'd0);
    write_reg(CFG_DEST_UNSIGNED, 5'd1);
    push_beat(8'h01, 1'b0);
    push_beat(8'h02, 1'b0);
    push_beat(8'h83, 1'b1);
    wait_idle();

    // Leave two bytes of a four-byte element open, then shrink the size so
    // the next byte completes the element at once.
    write_reg(CFG_SOURCE_BYTES, 5'd4);
    write_reg(CFG_DEST_SIZE, 5'd2);
    write_reg(CFG_DEST_UNSIGNED, 5'd0);
    push_beat(8'h11, 1'b0);
    push_beat(8'h22, 1'b0);
    wait_idle();
    write_reg(CFG_SOURCE_BYTES, 5'd1);
    push_beat(8'h33, 1'b1);
    wait_idle();

    // Boolean collapse with a zero size, which acts as one byte.
    write_reg(CFG_MODE, {3'b010, MODE_BOOL});
    write_reg(CFG_SOURCE_BYTES, 5'd0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b1);
    wait_idle();

    // Oversized source in reversal mode is clamped to eight bytes.
    write_reg(CFG_MODE, {3'b101, MODE_SWAP});
    write_reg(CFG_SOURCE_BYTES, 5'd31);
    for (int i = 0; i < 8; i++) push_beat(8'(1 << i), i == 7);
    wait_idle();

    // Random part: a fresh setting and idling profile in every phase.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      src_sel = $urandom_range(19);
      if (phase == 0) n = 31;
      else if (phase == 1) n = MaxSourceBytesDefault;
      else if (src_sel == 0) n = 0;
      else if (src_sel == 1) n = $urandom_range(31, 17);
      else if (src_sel <= 3) n = $urandom_range(16, 9);
      else n = $urandom_range(8, 1);
      write_reg(CFG_MODE, {3'($urandom_range(7)), 2'($urandom_range(3))});
      write_reg(CFG_LITTLE_ENDIAN, 5'($urandom_range(31)));
      write_reg(CFG_SOURCE_BYTES, 5'(n));
      write_reg(CFG_DEST_SIZE, 5'($urandom_range(31)));
      write_reg(CFG_DEST_UNSIGNED, 5'($urandom_range(31)));
      if ($urandom_range(3) == 0) write_reg(CfgIdxSpare, 5'($urandom_range(31)));

      phase_beats = 0;
      while (phase_beats < PhaseBeats) begin
        n = current_elem_bytes();
        kind = $urandom_range(9);
        if (kind <= 6) begin
          // Well-formed array of whole elements.
          elems = $urandom_range(4, 1);
          total = elems * n;
          for (int i = 0; i < total; i++) push_beat(pick_byte(), i == total - 1);
        end else if (kind == 7) begin
          // Array that ends part way into an element.
          elems = $urandom_range(2);
          total = elems * n + ((n > 1) ? $urandom_range(n - 1, 1) : 1);
          for (int i = 0; i < total; i++) push_beat(pick_byte(), i == total - 1);
        end else if (kind == 8) begin
          // Noise: random bytes with random array ends.
          total = $urandom_range(6, 1);
          for (int i = 0; i < total; i++) push_beat(pick_byte(), $urandom_range(3) == 0);
        end else begin
          // Whole elements with no array end.
          elems = $urandom_range(3, 1);
          total = elems * n;
          for (int i = 0; i < total; i++) push_beat(pick_byte(), 1'b0);
        end
        phase_beats += total;
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/befc_pkg.sv
src/befc_front.sv
src/befc_queue.sv
src/befc_back.sv
src/binary_element_format_converter_core.sv
tb/sv/tb_binary_element_format_converter_core.sv
